// File: rtl/alist_pkg.sv
// Shared types and constants for the array list engine.
package alist_pkg;

  // Default list capacity
  localparam int unsigned LIST_DEPTH_DEF = 128;

  // Fixed payload widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned OUT_W  = 8;

  // Request actions
  typedef enum logic [2:0] {
    ACT_APPEND   = 3'd0,
    ACT_DEL_LAST = 3'd1,
    ACT_DEL_AT   = 3'd2,
    ACT_SEARCH   = 3'd3,
    ACT_SRCH_DEL = 3'd4
  } alist_act_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_RANGE    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } alist_status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } alist_state_e;

  // One result transaction
  typedef struct packed {
    alist_status_e    status;
    logic             found;
    logic [OUT_W-1:0] removed_count;
    logic [OUT_W-1:0] list_length;
  } alist_res_t;

endpackage

// File: rtl/array_list_engine_unit.sv
// Array list engine: packed list of 32-bit values with append, delete and search.
// Append, delete last, errors and unused codes finish without a scan. Search and
// search-delete read all n elements, delete at position the elements behind the
// position, one element read per cycle; n is the count.
// One request at a time: a new request is taken once the result is in the output register.
// Reset: asynchronous, empties the list; the store itself is not cleared.
module array_list_engine_unit import alist_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               action_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic                     found_o,
  output logic [OUT_W-1:0]         removed_count_o,
  output logic [OUT_W-1:0]         list_length_o
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);

  logic              res_valid;
  logic              res_ready;
  alist_res_t        res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              out_valid_q, out_valid_d;
  alist_res_t        out_q;

  alist_seq #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  alist_mem #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = (res_valid && res_ready) ||
                       (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign found_o         = out_q.found;
  assign removed_count_o = out_q.removed_count;
  assign list_length_o   = out_q.list_length;

endmodule

// File: rtl/alist_mem.sv
// Element store: one write port, one read port with registered read data.
module alist_mem import alist_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
  localparam int unsigned AW = $clog2(LIST_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [LIST_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/alist_seq.sv
// Sequencer: decodes a request, walks the store one element a cycle
// through a single shared comparator, and forms the result.
module alist_seq import alist_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
  localparam int unsigned AW = $clog2(LIST_DEPTH),
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic [2:0]               action_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  // result
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output alist_res_t               res_o,
  // store
  output logic                     mem_we_o,
  output logic [AW-1:0]            mem_waddr_o,
  output logic [DATA_W-1:0]        mem_wdata_o,
  output logic                     mem_re_o,
  output logic [AW-1:0]            mem_raddr_o,
  input  logic [DATA_W-1:0]        mem_rdata_i
);

  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  alist_state_e      state_q, state_d;
  alist_act_e        op_q, op_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rd_q, rd_d;
  logic [CW-1:0]     wr_q, wr_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              found_q, found_d;
  logic              pend_q, pend_d;
  alist_res_t        res_q, res_d;

  logic              accept;
  logic              full;
  logic              empty;
  logic              out_of_range;
  logic              hit;
  logic              keep;
  logic              scan_end;

  assign accept       = req_valid_i && (state_q == S_IDLE);
  assign full         = (cnt_q == CW'(LIST_DEPTH));
  assign empty        = (cnt_q == '0);
  assign out_of_range = (CMPW'(position_i) >= CMPW'(cnt_q));

  // Shared comparator on the element read last cycle
  assign hit      = (mem_rdata_i == val_q);
  assign keep     = (op_q == ACT_DEL_AT) || ((op_q == ACT_SRCH_DEL) && !hit);
  assign scan_end = (rd_q == cnt_q) && !pend_q;

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    val_q   <= val_d;
    rd_q    <= rd_d;
    wr_q    <= wr_d;
    rem_q   <= rem_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  // Next state, store access and result
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    rem_d       = rem_q;
    found_d     = found_q;
    pend_d      = 1'b0;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = alist_act_e'(action_i);
          val_d   = value_i;
          rem_d   = '0;
          found_d = 1'b0;
          res_d.status        = STAT_OK;
          res_d.found         = 1'b0;
          res_d.removed_count = '0;
          res_d.list_length   = OUT_W'(cnt_q);
          state_d = S_DONE;
          unique case (action_i)
            ACT_APPEND: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_q[AW-1:0];
                mem_wdata_o = value_i;
                cnt_d       = cnt_q + CW'(1);
                res_d.list_length = OUT_W'(cnt_q + CW'(1));
              end
            end
            ACT_DEL_LAST: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
                res_d.removed_count = OUT_W'(1);
                res_d.list_length   = OUT_W'(cnt_q - CW'(1));
              end
            end
            ACT_DEL_AT: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else if (out_of_range) begin
                res_d.status = STAT_RANGE;
              end else begin
                rd_d    = CW'(position_i) + CW'(1);
                wr_d    = CW'(position_i);
                state_d = S_SCAN;
              end
            end
            ACT_SEARCH: begin
              rd_d    = '0;
              state_d = S_SCAN;
            end
            ACT_SRCH_DEL: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                rd_d    = '0;
                wr_d    = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              // unused codes: no operation
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue the next read
        if (rd_q != cnt_q) begin
          mem_re_o = 1'b1;
          rd_d     = rd_q + CW'(1);
          pend_d   = 1'b1;
        end
        // handle the element read last cycle
        if (pend_q) begin
          if (keep) begin
            mem_we_o = 1'b1;
            wr_d     = wr_q + CW'(1);
          end
          if (hit && (op_q != ACT_DEL_AT)) begin
            found_d = 1'b1;
            rem_d   = rem_q + CW'(1);
          end
        end
        if (scan_end) begin
          state_d = S_DONE;
          res_d.status        = STAT_OK;
          res_d.found         = 1'b0;
          res_d.removed_count = '0;
          res_d.list_length   = OUT_W'(cnt_q);
          unique case (op_q)
            ACT_DEL_AT: begin
              cnt_d = cnt_q - CW'(1);
              res_d.removed_count = OUT_W'(1);
              res_d.list_length   = OUT_W'(cnt_q - CW'(1));
            end
            ACT_SRCH_DEL: begin
              cnt_d = wr_q;
              res_d.found         = found_q;
              res_d.status        = found_q ? STAT_OK : STAT_NOTFOUND;
              res_d.removed_count = OUT_W'(rem_q);
              res_d.list_length   = OUT_W'(wr_q);
            end
            default: begin
              // search
              res_d.found  = found_q;
              res_d.status = found_q ? STAT_OK : STAT_NOTFOUND;
            end
          endcase
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// File: rtl/alist_chk.sv
// Port-level checks for the array list engine, bound to the top level.
module alist_chk import alist_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [2:0]               status_o,
  input logic                     found_o,
  input logic [OUT_W-1:0]         removed_count_o,
  input logic [OUT_W-1:0]         list_length_o
);

  // A result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  // One request at a time: ready drops after a request transaction
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // Count never exceeds capacity
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (LIST_DEPTH > 255) || (32'(list_length_o) <= LIST_DEPTH))
    else $error("list length beyond capacity");

  // A found flag only comes with a good status
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == STAT_OK)
    else $error("found with error status");

  // Removal only on success
  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (removed_count_o != '0) |-> status_o == STAT_OK)
    else $error("removal with error status");

endmodule

bind array_list_engine_unit alist_chk #(.LIST_DEPTH(LIST_DEPTH)) u_alist_chk (.*);

// File: verif/array_list_engine_unit_test.sv
// Self-checking testbench for array_list_engine_unit: directed table plus random list traffic.
`timescale 1ns / 1ps

module array_list_engine_unit_test;
  import alist_pkg::*;

  localparam int unsigned DEPTH       = LIST_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned IDLE_PCT    = 31;

  // Action codes the block treats as no-ops
  localparam logic [2:0] ACT_SPARE5 = 3'd5;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [2:0]        action_i    = ACT_APPEND;
  logic [DATA_W-1:0] value_i     = '0;
  logic [POS_W-1:0]  position_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [2:0]        status_o;
  logic              found_o;
  logic [OUT_W-1:0]  removed_count_o;
  logic [OUT_W-1:0]  list_length_o;

  // Directed stimulus row; expectation typed in only where typed_exp is set
  typedef struct {
    logic [2:0]        act;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0]  pos;
    bit                typed_exp;
    alist_status_e     st;
    bit                fnd;
    logic [OUT_W-1:0]  rm;
    logic [OUT_W-1:0]  len;
  } list_row_t;

  list_row_t directed_rows [24] = '{
    // empty list after reset
    '{ACT_DEL_LAST, 32'h0000_0000, 7'd0,   1'b1, STAT_EMPTY,    1'b0, 8'd0, 8'd0},
    '{ACT_DEL_AT,   32'h0000_0000, 7'd0,   1'b1, STAT_EMPTY,    1'b0, 8'd0, 8'd0},
    '{ACT_SEARCH,   32'h0000_0000, 7'd0,   1'b1, STAT_NOTFOUND, 1'b0, 8'd0, 8'd0},
    '{ACT_SRCH_DEL, 32'h0000_0000, 7'd0,   1'b1, STAT_EMPTY,    1'b0, 8'd0, 8'd0},
    // value extremes, with a run of duplicates at the tail
    '{ACT_APPEND,   32'h7FFF_FFFF, 7'd0,   1'b1, STAT_OK,       1'b0, 8'd0, 8'd1},
    '{ACT_APPEND,   32'h8000_0000, 7'd0,   1'b1, STAT_OK,       1'b0, 8'd0, 8'd2},
    '{ACT_APPEND,   32'hFFFF_FFFF, 7'd127, 1'b1, STAT_OK,       1'b0, 8'd0, 8'd3},
    '{ACT_APPEND,   32'h8000_0000, 7'd0,   1'b1, STAT_OK,       1'b0, 8'd0, 8'd4},
    '{ACT_APPEND,   32'h8000_0000, 7'd0,   1'b1, STAT_OK,       1'b0, 8'd0, 8'd5},
    '{ACT_SEARCH,   32'h8000_0000, 7'd0,   1'b1, STAT_OK,       1'b1, 8'd0, 8'd5},
    '{ACT_SEARCH,   32'h0000_0000, 7'd0,   1'b1, STAT_NOTFOUND, 1'b0, 8'd0, 8'd5},
    // position at and far beyond the count
    '{ACT_DEL_AT,   32'h0000_0000, 7'd5,   1'b1, STAT_RANGE,    1'b0, 8'd0, 8'd5},
    '{ACT_DEL_AT,   32'h0000_0000, 7'd127, 1'b1, STAT_RANGE,    1'b0, 8'd0, 8'd5},
    // adjacent duplicates must all go
    '{ACT_SRCH_DEL, 32'h8000_0000, 7'd0,   1'b1, STAT_OK,       1'b1, 8'd3, 8'd2},
    '{ACT_SRCH_DEL, 32'h0000_0005, 7'd0,   1'b1, STAT_NOTFOUND, 1'b0, 8'd0, 8'd2},
    // unused action codes leave the list alone
    '{ACT_SPARE5,   32'hFFFF_FFFF, 7'd127, 1'b1, STAT_OK,       1'b0, 8'd0, 8'd2},
    '{ACT_SPARE6,   32'h0000_0000, 7'd0,   1'b1, STAT_OK,       1'b0, 8'd0, 8'd2},
    '{ACT_SPARE7,   32'h0000_0000, 7'd0,   1'b1, STAT_OK,       1'b0, 8'd0, 8'd2},
    // shifting deletes, checked against the list model
    '{ACT_APPEND,   32'h0000_0001, 7'd0,   1'b0, STAT_OK,       1'b0, 8'd0, 8'd0},
    '{ACT_DEL_AT,   32'h0000_0000, 7'd1,   1'b0, STAT_OK,       1'b0, 8'd0, 8'd0},
    '{ACT_SEARCH,   32'h7FFF_FFFF, 7'd0,   1'b0, STAT_OK,       1'b0, 8'd0, 8'd0},
    '{ACT_DEL_AT,   32'h0000_0000, 7'd0,   1'b0, STAT_OK,       1'b0, 8'd0, 8'd0},
    '{ACT_DEL_LAST, 32'h0000_0000, 7'd0,   1'b1, STAT_OK,       1'b0, 8'd1, 8'd0},
    '{ACT_SRCH_DEL, 32'hFFFF_FFFF, 7'd0,   1'b1, STAT_EMPTY,    1'b0, 8'd0, 8'd0}
  };

  // Shadow copy of the list and results still owed by the block
  logic [DATA_W-1:0] shadow_list [DEPTH];
  int unsigned       shadow_len     = 0;
  alist_res_t        pending_results [$];

  bit          calm_stretch   = 1'b0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned peak_len       = 0;
  int unsigned full_rejects   = 0;
  int unsigned range_rejects  = 0;

  array_list_engine_unit #(
    .LIST_DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .found_o        (found_o),
    .removed_count_o(removed_count_o),
    .list_length_o  (list_length_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one request to the shadow list and return the result it should give
  function automatic alist_res_t apply_list_op(logic [2:0] act, logic [DATA_W-1:0] val,
                                               logic [POS_W-1:0] pos);
    alist_res_t  res;
    int unsigned n;
    int unsigned wr;
    int unsigned hits;
    res.status = STAT_OK;
    res.found  = 1'b0;
    hits       = 0;
    n          = shadow_len;
    case (act)
      ACT_APPEND: begin
        if (n >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          shadow_list[n] = val;
          n++;
        end
      end
      ACT_DEL_LAST: begin
        if (n == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          n--;
          hits = 1;
        end
      end
      ACT_DEL_AT: begin
        if (n == 0) begin
          res.status = STAT_EMPTY;
        end else if (pos >= n) begin
          res.status = STAT_RANGE;
        end else begin
          for (int unsigned k = pos; k + 1 < n; k++) shadow_list[k] = shadow_list[k + 1];
          n--;
          hits = 1;
        end
      end
      ACT_SEARCH: begin
        for (int unsigned k = 0; k < n; k++) if (shadow_list[k] == val) res.found = 1'b1;
        res.status = res.found ? STAT_OK : STAT_NOTFOUND;
      end
      ACT_SRCH_DEL: begin
        if (n == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          wr = 0;
          for (int unsigned k = 0; k < n; k++) begin
            if (shadow_list[k] == val) begin
              hits++;
            end else begin
              shadow_list[wr] = shadow_list[k];
              wr++;
            end
          end
          n          = wr;
          res.found  = (hits != 0);
          res.status = res.found ? STAT_OK : STAT_NOTFOUND;
        end
      end
      default: ;
    endcase
    shadow_len        = n;
    res.removed_count = hits[OUT_W-1:0];
    res.list_length   = n[OUT_W-1:0];
    return res;
  endfunction

  // Values lean on a small pool and on current contents so searches hit
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) begin
      case ($urandom_range(7))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h8000_0000;
        4:       return 32'h7FFF_FFFF;
        5:       return 32'h0000_0005;
        6:       return 32'h5555_AAAA;
        default: return 32'h0000_002A;
      endcase
    end else if (roll < 75 && shadow_len > 0) begin
      return shadow_list[$urandom_range(shadow_len - 1)];
    end
    return $urandom;
  endfunction

  // Positions mostly land inside the list, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_position();
    if (shadow_len > 0 && $urandom_range(99) < 70) return POS_W'($urandom_range(shadow_len - 1));
    return POS_W'($urandom_range(127));
  endfunction

  // Drive one request transaction; called and returns at a falling edge
  task automatic issue_request(input logic [2:0] act, input logic [DATA_W-1:0] val,
                               input logic [POS_W-1:0] pos, input bit use_typed,
                               input alist_res_t typed_res);
    alist_res_t exp_res;
    while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_res = apply_list_op(act, val, pos);
    if (use_typed) exp_res = typed_res;
    pending_results.push_back(exp_res);
    requests_sent++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    if (exp_res.status == STAT_FULL) full_rejects++;
    if (exp_res.status == STAT_RANGE) range_rejects++;
    @(negedge clk_i);
  endtask

  task automatic random_request(input logic [2:0] act);
    issue_request(act, pick_value(), pick_position(), 1'b0, '0);
  endtask

  // Mixed traffic; draining shifts the weights toward removal
  task automatic run_mixed(input int unsigned count, input bit draining);
    int unsigned roll;
    for (int unsigned k = 0; k < count; k++) begin
      calm_stretch = !draining && (k >= count / 4) && (k < count / 4 + 60);
      roll = $urandom_range(99);
      if (roll < (draining ? 15 : 35))      random_request(ACT_APPEND);
      else if (roll < (draining ? 30 : 45)) random_request(ACT_DEL_LAST);
      else if (roll < (draining ? 50 : 60)) random_request(ACT_DEL_AT);
      else if (roll < (draining ? 70 : 78)) random_request(ACT_SEARCH);
      else if (roll < (draining ? 96 : 94)) random_request(ACT_SRCH_DEL);
      else random_request(3'(5 + $urandom_range(2)));
    end
    calm_stretch = 1'b0;
  endtask

  // Result side stalls at random except during the calm stretch
  always @(negedge clk_i) begin
    out_ready_i <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    alist_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing pending: status %0d length %0d",
                   results_seen, status_o, list_length_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status || found_o !== exp_res.found ||
            removed_count_o !== exp_res.removed_count ||
            list_length_o !== exp_res.list_length) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result %0d: exp st=%0d fnd=%0d rm=%0d len=%0d, ",
                      "got st=%0d fnd=%0d rm=%0d len=%0d"},
                     results_seen, exp_res.status, exp_res.found, exp_res.removed_count,
                     exp_res.list_length, status_o, found_o, removed_count_o, list_length_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("array_list_engine_unit regression: fail");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    alist_res_t typed_res;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_rows[r]) begin
      typed_res.status        = directed_rows[r].st;
      typed_res.found         = directed_rows[r].fnd;
      typed_res.removed_count = directed_rows[r].rm;
      typed_res.list_length   = directed_rows[r].len;
      issue_request(directed_rows[r].act, directed_rows[r].val, directed_rows[r].pos,
                    directed_rows[r].typed_exp, typed_res);
    end

    // random: mixed, then fill to capacity and push past it, then drain
    run_mixed(130, 1'b0);
    while (shadow_len < DEPTH) random_request(ACT_APPEND);
    repeat (3) random_request(ACT_APPEND);
    random_request(ACT_SEARCH);
    issue_request(ACT_DEL_AT, pick_value(), 7'd127, 1'b0, '0);
    random_request(ACT_APPEND);
    random_request(ACT_APPEND);
    issue_request(ACT_DEL_AT, pick_value(), 7'd0, 1'b0, '0);
    random_request(ACT_SRCH_DEL);
    run_mixed(150, 1'b1);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 16) @(posedge clk_i);

    $display("covered %0d requests (%0d directed), %0d results checked, peak length %0d",
             requests_sent, $size(directed_rows), results_seen, peak_len);
    $display("rejects: %0d on a full list, %0d out-of-range positions; %0d mismatches",
             full_rejects, range_rejects, mismatch_count);
    if (mismatch_count == 0) begin
      $display("array_list_engine_unit regression: pass");
    end else begin
      $display("array_list_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/alist_pkg.sv
rtl/alist_mem.sv
rtl/alist_seq.sv
rtl/array_list_engine_unit.sv
rtl/alist_chk.sv
verif/array_list_engine_unit_test.sv
